// ===== sv/fcdma_pkg.sv =====
// shared types and constants of the four-channel dma controller
package fcdma_pkg;

  localparam int NUM_CH = 4;
  localparam int CH_W   = 2;
  localparam int ACT_W  = $clog2(NUM_CH + 1);

  localparam logic [27:0] ADDR_MASK      = 28'hFFF_FFFE;
  localparam logic [15:0] CTL_MASK7      = 16'hF7E0;
  localparam logic [15:0] CTL_MASK9      = 16'hFFE0;
  localparam logic [21:0] CNT_MASK9      = 22'h1F_FFFF;
  localparam logic [21:0] CNT_ZERO9      = 22'h20_0000;
  localparam logic [21:0] CNT_ZERO7_LAST = 22'h01_0000;
  localparam logic [21:0] CNT_ZERO7      = 22'h00_4000;
  localparam logic [CH_W-1:0] CH_LAST    = 2'd3;

  typedef enum logic [1:0] {
    CMD_SRC  = 2'd0,
    CMD_DST  = 2'd1,
    CMD_CTL  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_INC    = 2'd0,
    STEP_DEC    = 2'd1,
    STEP_FIX    = 2'd2,
    STEP_RELOAD = 2'd3
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_SRC  = 3'd1,
    OP_DST  = 3'd2,
    OP_CTL  = 3'd3,
    OP_DONE = 3'd4,
    OP_XFER = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [CH_W-1:0]  ch;
    logic             wide;
    step_t            src_step;
    step_t            dst_step;
    logic             ctl_load;
    logic             reload;
    logic [21:0]      left;
    logic [21:0]      cnt;
    logic [27:0]      addr;
    logic             irq_valid;
    logic [1:0]       irq_channel;
    logic [ACT_W-1:0] active_channel;
    logic             hold_cpu;
    logic [27:0]      read_back;
  } op_t;

  typedef struct packed {
    logic [27:0] start_src;
    logic [27:0] start_dst;
    logic [31:0] work_src;
    logic [31:0] work_dst;
    logic [21:0] ucnt;
  } entry_t;

  localparam entry_t ENTRY_RST = '{ucnt: CNT_ZERO9, default: '0};

  typedef struct packed {
    logic        xfer_valid;
    logic [31:0] read_addr;
    logic [31:0] write_addr;
    logic        wide;
  } xfer_res_t;

endpackage

// ===== sv/fcdma_if.sv =====
// input and result channel interfaces of the dma controller
interface fcdma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  channel;
  logic [31:0] wdata;
  logic        cpu_busy;

  modport source (output valid, cmd, channel, wdata, cpu_busy, input ready);
  modport sink (input valid, cmd, channel, wdata, cpu_busy, output ready);
endinterface

interface fcdma_out_if;
  logic        valid;
  logic        ready;
  logic        xfer_valid;
  logic [31:0] read_addr;
  logic [31:0] write_addr;
  logic        wide;
  logic        irq_valid;
  logic [1:0]  irq_channel;
  logic [2:0]  active_channel;
  logic        hold_cpu;
  logic [27:0] read_back;

  modport source (
    output valid, xfer_valid, read_addr, write_addr, wide, irq_valid, irq_channel,
           active_channel, hold_cpu, read_back,
    input  ready
  );
  modport sink (
    input  valid, xfer_valid, read_addr, write_addr, wide, irq_valid, irq_channel,
           active_channel, hold_cpu, read_back,
    output ready
  );
endinterface

// ===== sv/fcdma_ctx.sv =====
// per-channel address context memory with read-modify-write and forwarding
module fcdma_ctx
  import fcdma_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_ch,
  input  logic            wr_en,
  input  op_t             op,
  output xfer_res_t       res
);

  entry_t            mem_q [NUM_CH];
  logic [NUM_CH-1:0] vld_r;
  entry_t            rd_data_r;
  logic              rd_vld_r;
  logic              fwd_hit_r;
  entry_t            fwd_data_r;
  entry_t            entry_cur;
  entry_t            entry_new;
  logic [31:0]       unit;
  logic [31:0]       amask;
  logic              first;
  logic [31:0]       src;
  logic [31:0]       dst;

  function automatic logic [31:0] step_addr(input logic [31:0] a, input step_t code,
                                            input logic [31:0] u);
    logic [31:0] r;
    unique case (code)
      STEP_INC, STEP_RELOAD: r = a + u;
      STEP_DEC:              r = a - u;
      STEP_FIX:              r = a;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[op.ch] <= entry_new;
    end
    if (rd_en) begin
      rd_data_r  <= mem_q[rd_ch];
      fwd_data_r <= entry_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[op.ch] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_ch];
        fwd_hit_r <= wr_en && (op.ch == rd_ch);
      end
    end
  end

  assign entry_cur = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_data_r : ENTRY_RST);

  always_comb begin
    entry_new = entry_cur;
    res       = '0;
    unit      = op.wide ? 32'd4 : 32'd2;
    amask     = ~(unit - 32'd1);
    first     = (op.left == entry_cur.ucnt);
    src       = first ? (entry_cur.work_src & amask) : entry_cur.work_src;
    dst       = first ? (entry_cur.work_dst & amask) : entry_cur.work_dst;
    unique case (op.kind)
      OP_NONE: ;
      OP_SRC: begin
        entry_new.start_src = op.addr;
      end
      OP_DST: begin
        entry_new.start_dst = op.addr;
      end
      OP_CTL: begin
        entry_new.ucnt = op.cnt;
        if (op.ctl_load) begin
          entry_new.work_src = {4'b0, entry_cur.start_src};
          entry_new.work_dst = {4'b0, entry_cur.start_dst};
        end
      end
      OP_DONE: begin
        if (op.reload) begin
          entry_new.work_dst = {4'b0, entry_cur.start_dst};
        end
      end
      OP_XFER: begin
        res.xfer_valid     = 1'b1;
        res.read_addr      = src;
        res.write_addr     = dst;
        res.wide           = op.wide;
        entry_new.work_src = step_addr(src, op.src_step, unit);
        entry_new.work_dst = step_addr(dst, op.dst_step, unit);
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/four_channel_dma_controller.sv =====
// four-channel dma controller top level
// an accepted input beat is registered in the context stage, its result in the
// output register; throughput: one item per cycle while the output is ready,
// set by one context memory read-modify-write per cycle with write-back forwarding
// reset: enables, counts, done flags and bus hold clear, core_variant sets to 1;
// context entries read as their reset values until first written
module four_channel_dma_controller
  import fcdma_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  fcdma_in_if.sink           in_if,
  fcdma_out_if.source        out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic       REG_CORE_VARIANT = 1'b0;
  localparam logic [2:0] TIMING_NOW       = 3'd0;

  logic                    cv_r;
  logic [NUM_CH-1:0][15:0] ctl_r, ctl_nxt;
  logic [NUM_CH-1:0][21:0] left_r, left_nxt;
  logic [NUM_CH-1:0]       fin_r, fin_nxt;
  logic                    hold_r, hold_nxt;
  logic [NUM_CH-1:0]       pend, pend_nxt, fin_bad;

  logic                    in_acc;
  logic                    s1_v_r;
  op_t                     s1_op_r;
  logic                    s1_adv;
  op_t                     op;
  xfer_res_t               res;
  logic                    out_v_r;
  op_t                     out_op_r;
  xfer_res_t               out_res_r;

  cmd_t                    cmd;
  logic [CH_W-1:0]         ch;
  logic                    ch_ok;
  logic [21:0]             cnt_w;
  logic [15:0]             ctl_w;
  logic [ACT_W-1:0]        srv;
  logic [CH_W-1:0]         srv_ch;
  logic [15:0]             srv_ctl;

  function automatic logic [ACT_W-1:0] first_pend(input logic [NUM_CH-1:0] p);
    logic [ACT_W-1:0] r;
    r = ACT_W'(NUM_CH);
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (p[i]) begin
        r = ACT_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] timing_of(input logic [15:0] c, input logic v);
    return v ? c[13:11] : {1'b0, c[13:12]};
  endfunction

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CORE_VARIANT) ? {31'b0, cv_r} : '0;

  // handshake
  assign s1_adv       = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !s1_v_r || s1_adv;
  assign in_acc       = in_if.valid && in_if.ready;

  assign cmd    = cmd_t'(in_if.cmd);
  assign ch     = in_if.channel;
  assign ch_ok  = ({1'b0, ch} < ACT_W'(NUM_CH));

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      pend[i]    = ctl_r[i][15] && ((left_r[i] != '0) || fin_r[i]);
      fin_bad[i] = fin_r[i] && (left_r[i] != '0);
    end
    srv     = first_pend(pend);
    srv_ch  = srv[CH_W-1:0];
    srv_ctl = ctl_r[srv_ch];
  end

  // count and control decode of a control write
  always_comb begin
    if (cv_r) begin
      cnt_w = in_if.wdata[21:0] & CNT_MASK9;
      if (cnt_w == '0) begin
        cnt_w = CNT_ZERO9;
      end
      ctl_w = in_if.wdata[31:16] & CTL_MASK9;
    end else begin
      cnt_w = {6'b0, in_if.wdata[15:0]};
      if (cnt_w == '0) begin
        cnt_w = (ch == CH_LAST) ? CNT_ZERO7_LAST : CNT_ZERO7;
      end
      ctl_w = in_if.wdata[31:16] & CTL_MASK7;
    end
  end

  // channel control update and operation for the context stage
  always_comb begin
    ctl_nxt  = ctl_r;
    left_nxt = left_r;
    fin_nxt  = fin_r;
    hold_nxt = hold_r;
    op       = '0;
    op.kind  = OP_NONE;
    op.ch    = ch;
    op.addr  = in_if.wdata[27:0] & ADDR_MASK;
    unique case (cmd)
      CMD_SRC: begin
        op.read_back = op.addr;
        if (ch_ok) begin
          op.kind = OP_SRC;
        end
      end
      CMD_DST: begin
        op.read_back = op.addr;
        if (ch_ok) begin
          op.kind = OP_DST;
        end
      end
      CMD_CTL: begin
        if (ch_ok) begin
          op.kind     = OP_CTL;
          op.cnt      = cnt_w;
          ctl_nxt[ch] = ctl_w;
          if (!ctl_r[ch][15] && ctl_w[15]) begin
            op.ctl_load = 1'b1;
            if (timing_of(ctl_w, cv_r) == TIMING_NOW) begin
              left_nxt[ch] = cnt_w;
              fin_nxt[ch]  = 1'b0;
            end
          end
        end
      end
      CMD_TICK: begin
        if (srv != ACT_W'(NUM_CH)) begin
          op.ch = srv_ch;
          if (left_r[srv_ch] == '0) begin
            op.kind         = OP_DONE;
            fin_nxt[srv_ch] = 1'b0;
            if (!srv_ctl[9] || (timing_of(srv_ctl, cv_r) == TIMING_NOW)) begin
              ctl_nxt[srv_ch][15] = 1'b0;
            end
            op.reload = (step_t'(srv_ctl[6:5]) == STEP_RELOAD);
            if (srv_ctl[14]) begin
              op.irq_valid   = 1'b1;
              op.irq_channel = srv_ch;
            end
          end else if (!in_if.cpu_busy) begin
            op.kind          = OP_XFER;
            op.wide          = srv_ctl[10];
            op.src_step      = step_t'(srv_ctl[8:7]);
            op.dst_step      = step_t'(srv_ctl[6:5]);
            op.left          = left_r[srv_ch];
            left_nxt[srv_ch] = left_r[srv_ch] - 22'd1;
            if (left_r[srv_ch] == 22'd1) begin
              fin_nxt[srv_ch] = 1'b1;
            end
            hold_nxt = 1'b1;
          end
        end
      end
    endcase
    for (int i = 0; i < NUM_CH; i++) begin
      pend_nxt[i] = ctl_nxt[i][15] && ((left_nxt[i] != '0) || fin_nxt[i]);
    end
    op.active_channel = first_pend(pend_nxt);
    if (op.active_channel == ACT_W'(NUM_CH)) begin
      hold_nxt = 1'b0;
    end
    op.hold_cpu = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r    <= 1'b1;
      ctl_r   <= '0;
      left_r  <= '0;
      fin_r   <= '0;
      hold_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr[2] == REG_CORE_VARIANT)) begin
        cv_r <= cfg_pwdata[0];
      end
      if (in_acc) begin
        ctl_r  <= ctl_nxt;
        left_r <= left_nxt;
        fin_r  <= fin_nxt;
        hold_r <= hold_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= op;
    end
    if (s1_adv) begin
      out_op_r  <= s1_op_r;
      out_res_r <= res;
    end
  end

  fcdma_ctx u_ctx (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .rd_ch (op.ch),
    .wr_en (s1_adv && (s1_op_r.kind != OP_NONE)),
    .op    (s1_op_r),
    .res   (res)
  );

  assign out_if.valid          = out_v_r;
  assign out_if.xfer_valid     = out_res_r.xfer_valid;
  assign out_if.read_addr      = out_res_r.read_addr;
  assign out_if.write_addr     = out_res_r.write_addr;
  assign out_if.wide           = out_res_r.wide;
  assign out_if.irq_valid      = out_op_r.irq_valid;
  assign out_if.irq_channel    = out_op_r.irq_channel;
  assign out_if.active_channel = out_op_r.active_channel;
  assign out_if.hold_cpu       = out_op_r.hold_cpu;
  assign out_if.read_back      = out_op_r.read_back;

`ifndef SYNTH
  a_hold_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (pend != '0))
    else $error("bus hold with no channel pending");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_v_r && out_v_r))
    else $error("input stalled with a free stage");

  a_done_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    fin_bad == '0)
    else $error("done flag set with units left");

  a_xfer_holds_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.xfer_valid) |-> out_op_r.hold_cpu)
    else $error("transfer issued without bus hold");
`endif

endmodule
